FILE: hw/rtl/xs_pkg.sv
// Package for the XMODEM sender: protocol bytes, command codes and the
// command and status bundles that join the controller and the datapath.
// No dependencies.
package xs_pkg;

	localparam int unsigned MEM_DEPTH_DEF = 65536;
	localparam int unsigned PACKET_BYTES  = 128;
	localparam int unsigned SIZE_W        = 17;
	localparam logic [SIZE_W-1:0] MAX_SIZE = 17'h10000;

	localparam logic [7:0] C_SOH = 8'h01;
	localparam logic [7:0] C_EOT = 8'h04;
	localparam logic [7:0] C_ACK = 8'h06;
	localparam logic [7:0] C_NAK = 8'h15;
	localparam logic [7:0] C_CAN = 8'h18;
	localparam logic [7:0] C_CRC = 8'h43;
	localparam logic [7:0] C_PAD = 8'h1A;

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_RX      = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;

	localparam logic [1:0] PH_XFER   = 2'd0;
	localparam logic [1:0] PH_EOTACK = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;
	localparam logic [1:0] PH_CANCEL = 2'd3;

	localparam logic [2:0] SEL_SOH    = 3'd0;
	localparam logic [2:0] SEL_BN     = 3'd1;
	localparam logic [2:0] SEL_BNC    = 3'd2;
	localparam logic [2:0] SEL_DATA   = 3'd3;
	localparam logic [2:0] SEL_CHK_HI = 3'd4;
	localparam logic [2:0] SEL_CHK_LO = 3'd5;
	localparam logic [2:0] SEL_EOT    = 3'd6;
	localparam logic [2:0] SEL_NAK    = 3'd7;

	typedef struct packed {
		logic       wr;
		logic       sess_rst;
		logic       start;
		logic       start_crc;
		logic       set_phase;
		logic [1:0] phase_val;
		logic       advance;
		logic       push;
		logic [2:0] sel;
		logic       final_beat;
		logic       empty;
		logic       chk_clr;
		logic       rd_first;
		logic       data_step;
		logic       save;
		logic       resend;
	} dp_cmd_t;

	typedef struct packed {
		logic       started;
		logic       crc_mode;
		logic [1:0] phase;
		logic       rem_zero;
		logic       i_last;
		logic       push_ok;
	} dp_stat_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ 16'h1021;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/xs_ctrl.sv
// Controller of the XMODEM sender: decides the reply to each input beat and
// sequences the bytes of a reply. Depends on xs_pkg.
module xs_ctrl import xs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_cmd,
	input  logic [15:0] in_address,
	input  logic [7:0] in_byte,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_NEXT  = 3'd1;
	localparam logic [2:0] S_HDR   = 3'd2;
	localparam logic [2:0] S_DATA  = 3'd3;
	localparam logic [2:0] S_CHK   = 3'd4;
	localparam logic [2:0] S_ONE   = 3'd5;
	localparam logic [2:0] S_EMPTY = 3'd6;

	logic [2:0] state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic       resend_q, resend_d;
	logic [2:0] sel_q, sel_d;
	logic [7:0] rx;

	assign in_ready = (state_q == S_IDLE);
	assign rx = (in_cmd == CMD_RX) ? in_byte : 8'h00;

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		resend_d = resend_q;
		sel_d    = sel_q;
		cmd      = '0;
		cmd.resend = resend_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_LOAD) begin
						cmd.wr = 1'b1;
						cmd.sess_rst = (in_address == 16'h0000);
					end else if (in_cmd == CMD_RX || in_cmd == CMD_TIMEOUT) begin
						if (stat.phase == PH_DONE || stat.phase == PH_CANCEL) begin
							state_d = S_EMPTY;
						end else if (stat.phase == PH_EOTACK) begin
							if (rx == C_ACK) begin
								cmd.set_phase = 1'b1;
								cmd.phase_val = PH_DONE;
								state_d = S_EMPTY;
							end else begin
								sel_d = SEL_EOT;
								state_d = S_ONE;
							end
						end else begin
							case (rx)
								C_CRC: begin
									if (stat.started) begin
										sel_d = SEL_NAK;
										state_d = S_ONE;
									end else begin
										cmd.start = 1'b1;
										cmd.start_crc = 1'b1;
										state_d = S_NEXT;
									end
								end
								C_ACK: begin
									if (stat.started) begin
										state_d = S_NEXT;
									end else begin
										sel_d = SEL_NAK;
										state_d = S_ONE;
									end
								end
								C_NAK: begin
									if (stat.started) begin
										resend_d = 1'b1;
										idx_d = 2'd0;
										state_d = S_HDR;
									end else begin
										cmd.start = 1'b1;
										state_d = S_NEXT;
									end
								end
								C_CAN: begin
									cmd.set_phase = 1'b1;
									cmd.phase_val = PH_CANCEL;
									state_d = S_EMPTY;
								end
								default: begin
									if (stat.started) begin
										resend_d = 1'b1;
										idx_d = 2'd0;
										state_d = S_HDR;
									end else begin
										state_d = S_EMPTY;
									end
								end
							endcase
						end
					end
				end
			end
			S_NEXT: begin
				if (stat.rem_zero) begin
					cmd.set_phase = 1'b1;
					cmd.phase_val = PH_EOTACK;
					sel_d = SEL_EOT;
					state_d = S_ONE;
				end else begin
					cmd.advance = 1'b1;
					resend_d = 1'b0;
					idx_d = 2'd0;
					state_d = S_HDR;
				end
			end
			S_HDR: begin
				if (stat.push_ok) begin
					cmd.push = 1'b1;
					case (idx_q)
						2'd0: begin
							cmd.sel = SEL_SOH;
							cmd.chk_clr = 1'b1;
						end
						2'd1: cmd.sel = SEL_BN;
						default: cmd.sel = SEL_BNC;
					endcase
					if (idx_q == 2'd2) begin
						cmd.rd_first = 1'b1;
						state_d = S_DATA;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
			S_DATA: begin
				if (stat.push_ok) begin
					cmd.push = 1'b1;
					cmd.sel = SEL_DATA;
					cmd.data_step = 1'b1;
					if (stat.i_last) begin
						idx_d = 2'd0;
						state_d = S_CHK;
					end
				end
			end
			S_CHK: begin
				if (stat.push_ok) begin
					cmd.push = 1'b1;
					if (stat.crc_mode && idx_q == 2'd0) begin
						cmd.sel = SEL_CHK_HI;
						idx_d = 2'd1;
					end else begin
						cmd.sel = SEL_CHK_LO;
						cmd.final_beat = 1'b1;
						cmd.save = !resend_q;
						state_d = S_IDLE;
					end
				end
			end
			S_ONE: begin
				if (stat.push_ok) begin
					cmd.push = 1'b1;
					cmd.sel = sel_q;
					cmd.final_beat = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (stat.push_ok) begin
					cmd.push = 1'b1;
					cmd.empty = 1'b1;
					cmd.final_beat = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= 2'd0;
			resend_q <= 1'b0;
			sel_q    <= SEL_EOT;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			resend_q <= resend_d;
			sel_q    <= sel_d;
		end
	end

endmodule

FILE: hw/rtl/xs_datapath.sv
// Datapath of the XMODEM sender: file store, session registers, check
// accumulator, beat packer and output register. Depends on xs_pkg.
module xs_datapath import xs_pkg::*; #(
	parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  logic [15:0]       in_address,
	input  logic [7:0]        in_byte,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       out_word,
	output logic [3:0]        out_cnt,
	output logic              out_last,
	output logic [1:0]        out_status
);

	localparam int unsigned AW = $clog2(MEM_DEPTH);
	localparam int unsigned XW = (AW > 16) ? AW : 16;
	localparam int unsigned SW = (AW > 18) ? AW : 18;

	logic [7:0] mem [MEM_DEPTH];
	logic [7:0] rdata_q;

	logic [SIZE_W-1:0] total_q, remaining_q, offset_q;
	logic [7:0]  bn_q, len_q;
	logic        started_q, crc_q;
	logic [1:0]  phase_q;
	logic [15:0] saved_q, chk_q, chk_val;
	logic [6:0]  i_q;
	logic [63:0] word_q, new_word;
	logic [3:0]  cnt_q, new_cnt;
	logic        flush, out_valid_q, push_ok;
	logic [7:0]  byte_v, data_b, bn_prev, n_len;
	logic [7:0]  rd_i;
	logic [XW-1:0] addr_x;
	logic [SW-1:0] rd_sum;

	assign addr_x = XW'(in_address);
	assign rd_i   = cmd.rd_first ? 8'd0 : ({1'b0, i_q} + 8'd1);
	assign rd_sum = SW'(offset_q) + SW'(rd_i);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr_x[AW-1:0]] <= in_byte;
		end
		if (cmd.rd_first || cmd.data_step) begin
			rdata_q <= mem[rd_sum[AW-1:0]];
		end
	end

	assign bn_prev = bn_q - 8'd1;
	assign data_b  = ({1'b0, i_q} < len_q) ? rdata_q : C_PAD;
	assign chk_val = cmd.resend ? saved_q : chk_q;
	assign n_len   = (remaining_q > SIZE_W'(PACKET_BYTES)) ? 8'(PACKET_BYTES)
		: remaining_q[7:0];

	always_comb begin
		case (cmd.sel)
			SEL_SOH:    byte_v = C_SOH;
			SEL_BN:     byte_v = bn_prev;
			SEL_BNC:    byte_v = ~bn_prev;
			SEL_DATA:   byte_v = data_b;
			SEL_CHK_HI: byte_v = chk_val[15:8];
			SEL_CHK_LO: byte_v = chk_val[7:0];
			SEL_EOT:    byte_v = C_EOT;
			SEL_NAK:    byte_v = C_NAK;
			default:    byte_v = C_PAD;
		endcase
	end

	always_comb begin
		if (cmd.empty) begin
			new_word = word_q;
			new_cnt  = cnt_q;
		end else begin
			new_word = word_q | (64'(byte_v) << {cnt_q[2:0], 3'b000});
			new_cnt  = cnt_q + 4'd1;
		end
		flush = cmd.final_beat || (new_cnt == 4'd8);
	end

	assign push_ok = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			remaining_q <= '0;
			offset_q    <= '0;
			len_q       <= 8'd0;
			bn_q        <= 8'd1;
			started_q   <= 1'b0;
			crc_q       <= 1'b0;
			phase_q     <= PH_XFER;
			saved_q     <= 16'd0;
			chk_q       <= 16'd0;
			i_q         <= 7'd0;
			word_q      <= 64'd0;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (cmd.sess_rst) begin
				remaining_q <= '0;
				offset_q    <= '0;
				len_q       <= 8'd0;
				bn_q        <= 8'd1;
				started_q   <= 1'b0;
				crc_q       <= 1'b0;
				phase_q     <= PH_XFER;
				saved_q     <= 16'd0;
			end
			if (cmd.start) begin
				remaining_q <= (total_q > MAX_SIZE) ? MAX_SIZE : total_q;
				crc_q       <= cmd.start_crc;
				offset_q    <= '0;
				len_q       <= 8'd0;
			end
			if (cmd.set_phase) begin
				phase_q <= cmd.phase_val;
			end
			if (cmd.advance) begin
				remaining_q <= remaining_q - SIZE_W'(n_len);
				offset_q    <= offset_q + SIZE_W'(len_q);
				len_q       <= n_len;
				bn_q        <= bn_q + 8'd1;
				started_q   <= 1'b1;
			end
			if (cmd.chk_clr) begin
				chk_q <= 16'd0;
			end
			if (cmd.rd_first) begin
				i_q <= 7'd0;
			end
			if (cmd.data_step) begin
				i_q <= i_q + 7'd1;
				if (crc_q) begin
					chk_q <= crc_step(chk_q, data_b);
				end else begin
					chk_q <= {8'h00, chk_q[7:0] + data_b};
				end
			end
			if (cmd.save) begin
				saved_q <= chk_q;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.push) begin
				if (flush) begin
					word_q      <= 64'd0;
					cnt_q       <= 4'd0;
					out_valid_q <= 1'b1;
				end else begin
					word_q <= new_word;
					cnt_q  <= new_cnt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && flush) begin
			out_word   <= new_word;
			out_cnt    <= new_cnt;
			out_last   <= cmd.final_beat;
			out_status <= phase_q;
		end
	end

	assign out_valid = out_valid_q;

	assign stat.started  = started_q;
	assign stat.crc_mode = crc_q;
	assign stat.phase    = phase_q;
	assign stat.rem_zero = (remaining_q == '0);
	assign stat.i_last   = (i_q == 7'h7F);
	assign stat.push_ok  = push_ok;

endmodule

FILE: hw/rtl/xmodem_sender_unit.sv
// Top level of the XMODEM sender: joins the controller and the datapath.
// Depends on xs_pkg, xs_ctrl and xs_datapath.
//
// Usage: file bytes are loaded with input beats of kind load (tuser 0) at
// their store address; a load at address 0 restarts the session. Beats of
// kind receive (tuser 1) carry a byte from the receiver, kind timeout (2)
// marks a receive timeout. cfg_we writes the file length before a transfer.
// Each receive or timeout beat produces one or more output beats of up to
// eight transmit bytes each; tlast marks the final beat of that reply.
// Loads produce nothing. In a packet reply one byte per cycle leaves the
// packet byte sequencer while the receiver does not stall; the sequencer
// reads the file store and updates the checksum or CRC one byte at a time,
// and 17 output beats result. A new input beat is taken once the last byte
// of a reply has entered the output register. When the receiver stalls, the
// sequencer waits with the output register full and resumes without loss.
// Reset returns the session to its start and clears the length register;
// the store keeps no reset value and needs no clearing pass.
module xmodem_sender_unit import xs_pkg::*; #(
	parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [23:0]       s_axis_tdata,  // address[15:0], byte_value[23:16]
	input  logic [1:0]        s_axis_tuser,  // cmd[1:0]
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [71:0]       m_axis_tdata,  // tx_bytes[63:0], tx_count[67:64], status[69:68]
	output logic              m_axis_tlast
);

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [63:0] out_word;
	logic [3:0]  out_cnt;
	logic [1:0]  out_status;

	xs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_cmd     (s_axis_tuser),
		.in_address (s_axis_tdata[15:0]),
		.in_byte    (s_axis_tdata[23:16]),
		.stat       (stat),
		.cmd        (cmd)
	);

	xs_datapath #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_address (s_axis_tdata[15:0]),
		.in_byte    (s_axis_tdata[23:16]),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_word   (out_word),
		.out_cnt    (out_cnt),
		.out_last   (m_axis_tlast),
		.out_status (out_status)
	);

	assign m_axis_tdata = {2'b00, out_status, out_cnt, out_word};

endmodule

FILE: test/tb_xmodem_sender_unit.sv
// Self-checking testbench for xmodem_sender_unit: drives load, receive and timeout beats,
// predicts every reply packet, EOT and NAK from its own protocol model and checks each beat.
// Depends on xs_pkg and the RTL of the sender unit only.
`timescale 1ns / 100ps

module tb_xmodem_sender_unit;
	import xs_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int FILE_SPAN = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] addr;
		logic [7:0]  val;
	} host_item_t;

	typedef struct {
		logic [63:0] tx;
		logic [3:0]  cnt;
		logic        last;
		logic [1:0]  status;
	} tx_beat_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	logic s_axis_tvalid, s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid, m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic m_axis_tlast;

	xmodem_sender_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	host_item_t pending_items[$];
	tx_beat_t   expected_beats[$];
	int errors = 0;
	bit no_idle = 0;

	// Protocol model state.
	logic [7:0]  file_mem [0:65535];
	logic [16:0] file_size;
	logic [7:0]  blk_num;
	logic        xfer_started, use_crc;
	int unsigned bytes_left, pkt_start, pkt_len;
	logic [15:0] last_check;
	logic [1:0]  xfer_phase;
	logic [7:0]  tx_line[$];

	function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		repeat (8) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		return c;
	endfunction

	task automatic restart_session();
		blk_num = 8'd1;
		xfer_started = 0;
		use_crc = 0;
		bytes_left = 0;
		pkt_start = 0;
		pkt_len = 0;
		last_check = 16'h0;
		xfer_phase = PH_XFER;
	endtask

	task automatic build_packet(input logic [7:0] bn, input int unsigned off,
		input int unsigned n, input bit keep_saved, output logic [15:0] chk);
		logic [7:0] b;
		chk = 16'h0;
		tx_line.push_back(C_SOH);
		tx_line.push_back(bn);
		tx_line.push_back(~bn);
		for (int i = 0; i < PACKET_BYTES; i++) begin
			b = (i < n) ? file_mem[(off + i) % 65536] : C_PAD;
			tx_line.push_back(b);
			chk = use_crc ? crc16_byte(chk, b) : {8'h00, chk[7:0] + b};
		end
		if (keep_saved) chk = last_check;
		if (use_crc) tx_line.push_back(chk[15:8]);
		tx_line.push_back(chk[7:0]);
	endtask

	task automatic send_next_packet();
		int unsigned n;
		logic [15:0] chk;
		if (bytes_left == 0) begin
			tx_line.push_back(C_EOT);
			xfer_phase = PH_EOTACK;
			return;
		end
		n = bytes_left > PACKET_BYTES ? PACKET_BYTES : bytes_left;
		pkt_start = pkt_start + pkt_len;
		bytes_left -= n;
		pkt_len = n;
		build_packet(blk_num, pkt_start, n, 0, chk);
		last_check = chk;
		blk_num++;
		xfer_started = 1;
	endtask

	task automatic start_transfer(input bit crc);
		bytes_left = 32'(file_size > MAX_SIZE ? MAX_SIZE : file_size);
		use_crc = crc;
		pkt_start = 0;
		pkt_len = 0;
		send_next_packet();
	endtask

	task automatic resend_packet();
		logic [15:0] chk;
		build_packet(blk_num - 8'd1, pkt_start, pkt_len, 1, chk);
	endtask

	task automatic predict_reply(input host_item_t it);
		logic [7:0] rx;
		tx_beat_t bt;
		int nres;
		if (it.cmd == CMD_LOAD) begin
			file_mem[it.addr] = it.val;
			if (it.addr == 0) restart_session();
			return;
		end
		if (it.cmd == CMD_NONE) return;
		tx_line.delete();
		rx = (it.cmd == CMD_RX) ? it.val : 8'h00;
		if (xfer_phase == PH_EOTACK) begin
			if (rx == C_ACK) xfer_phase = PH_DONE;
			else tx_line.push_back(C_EOT);
		end else if (xfer_phase == PH_XFER) begin
			case (rx)
				C_CRC: begin
					if (xfer_started) tx_line.push_back(C_NAK);
					else start_transfer(1);
				end
				C_ACK: begin
					if (xfer_started) send_next_packet();
					else tx_line.push_back(C_NAK);
				end
				C_NAK: begin
					if (xfer_started) resend_packet();
					else start_transfer(0);
				end
				C_CAN: xfer_phase = PH_CANCEL;
				default: begin
					if (xfer_started) resend_packet();
				end
			endcase
		end
		nres = (tx_line.size() == 0) ? 1 : (tx_line.size() + 7) / 8;
		for (int k = 0; k < nres; k++) begin
			bt.tx = 64'h0;
			bt.cnt = 4'd0;
			for (int j = 0; j < 8; j++) begin
				if (k * 8 + j < tx_line.size()) begin
					bt.tx[8 * j +: 8] = tx_line[k * 8 + j];
					bt.cnt++;
				end
			end
			bt.last = (k + 1 == nres);
			bt.status = xfer_phase;
			expected_beats.push_back(bt);
		end
	endtask

	// Clock and reset.
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1;
	end

	// Input driver.
	bit s_took, m_took;
	int s_gap = 0;
	always @(posedge clk) s_took <= s_axis_tvalid && s_axis_tready;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else if (!s_axis_tvalid || s_took) begin
			if (s_gap > 0) begin
				s_gap <= s_gap - 1;
				s_axis_tvalid <= 0;
			end else if (pending_items.size() > 0) begin
				host_item_t it;
				it = pending_items.pop_front();
				s_axis_tdata <= {it.val, it.addr};
				s_axis_tuser <= it.cmd;
				s_axis_tvalid <= 1;
				s_gap <= no_idle ? 0 : $urandom_range(0, 9);
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		host_item_t it;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			it.cmd = s_axis_tuser;
			it.addr = s_axis_tdata[15:0];
			it.val = s_axis_tdata[23:16];
			predict_reply(it);
		end
	end

	// Output monitor with random back-pressure and one long hold-off.
	int m_gap = 0, beats_seen = 0, hold_left = 0;
	bit hold_done = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 0;
		end else if (!hold_done && beats_seen >= 60) begin
			hold_done <= 1;
			hold_left <= LONG_HOLD;
			m_axis_tready <= 0;
		end else if (!m_axis_tready || m_took) begin
			if (m_gap > 0) begin
				m_gap <= m_gap - 1;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
				m_gap <= no_idle ? 0 : $urandom_range(0, 9);
			end
		end
	end

	always @(posedge clk) begin
		tx_beat_t e;
		m_took <= m_axis_tvalid && m_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_seen <= beats_seen + 1;
			if (expected_beats.size() == 0) begin
				$error("unexpected output beat tx_bytes=%h", m_axis_tdata[63:0]);
				errors++;
			end else begin
				e = expected_beats.pop_front();
				if (m_axis_tdata[63:0] !== e.tx) begin
					$error("tx_bytes: expected %h, got %h", e.tx, m_axis_tdata[63:0]);
					errors++;
				end
				if (m_axis_tdata[67:64] !== e.cnt) begin
					$error("tx_count: expected %0d, got %0d", e.cnt, m_axis_tdata[67:64]);
					errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last: expected %0b, got %0b", e.last, m_axis_tlast);
					errors++;
				end
				if (m_axis_tdata[69:68] !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, m_axis_tdata[69:68]);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stimulus.
	task automatic push_item(input logic [1:0] cmd, input logic [15:0] addr,
		input logic [7:0] val);
		host_item_t it;
		it.cmd = cmd;
		it.addr = addr;
		it.val = val;
		pending_items.push_back(it);
	endtask

	task automatic rx_byte(input logic [7:0] b);
		push_item(CMD_RX, 16'($urandom), b);
	endtask

	task automatic wait_idle_and_set(input logic [16:0] size);
		wait (pending_items.size() == 0 && !s_axis_tvalid && expected_beats.size() == 0);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= size;
		file_size = size;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// Oversized files are filled in order only up to FILE_SPAN, so at most two packets
	// are requested there, and stray receive bytes never act as an extra ACK.
	task automatic random_session(input logic [16:0] size);
		int acks;
		int r;
		logic [7:0] b;
		acks = 0;
		push_item(CMD_LOAD, 16'd0, 8'($urandom));
		rx_byte(($urandom_range(0, 1) == 1) ? C_CRC : C_NAK);
		repeat ($urandom_range(15, 40)) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				if (size > FILE_SPAN && acks >= 1) begin
					rx_byte(C_NAK);
				end else begin
					rx_byte(C_ACK);
					acks++;
				end
			end else if (r < 55) rx_byte(C_NAK);
			else if (r < 63) push_item(CMD_TIMEOUT, 16'($urandom), 8'($urandom));
			else if (r < 67) rx_byte(C_CRC);
			else if (r < 69) rx_byte(C_CAN);
			else if (r < 80) begin
				b = 8'($urandom);
				rx_byte((b == C_ACK) ? C_NAK : b);
			end
			else if (r < 86) push_item(CMD_LOAD, 16'($urandom_range(1, FILE_SPAN - 1)),
				8'($urandom));
			else if (r < 92) push_item(CMD_LOAD, 16'($urandom_range(FILE_SPAN, 65535)),
				8'($urandom));
			else if (r < 94) push_item(CMD_NONE, 16'($urandom), 8'($urandom));
			else if (r < 96) begin
				push_item(CMD_LOAD, 16'd0, 8'($urandom));
				rx_byte(($urandom_range(0, 1) == 1) ? C_CRC : C_NAK);
				acks = 0;
			end else rx_byte(C_ACK ^ (8'h1 << $urandom_range(0, 7)));
		end
	endtask

	initial begin
		logic [16:0] sz;
		cfg_we = 0;
		cfg_wdata = '0;
		restart_session();
		file_size = '0;
		for (int i = 0; i < 65536; i++) file_mem[i] = 8'h00;
		@(posedge arst_n);
		wait_idle_and_set(17'd300);
		for (int a = 0; a < FILE_SPAN; a++) push_item(CMD_LOAD, 16'(a), 8'($urandom));

		rx_byte(C_ACK);
		rx_byte(8'h55);
		push_item(CMD_TIMEOUT, 16'hFFFF, 8'hFF);
		rx_byte(C_CRC);
		rx_byte(C_CRC);
		rx_byte(C_NAK);
		push_item(CMD_TIMEOUT, 16'h0000, 8'h00);
		push_item(CMD_LOAD, 16'd5, 8'hFF);
		rx_byte(8'h77);
		rx_byte(C_ACK);
		rx_byte(C_ACK);
		rx_byte(C_ACK);
		rx_byte(C_NAK);
		rx_byte(C_CAN);
		rx_byte(C_ACK);
		rx_byte(C_ACK);
		push_item(CMD_NONE, 16'hFFFF, 8'hFF);

		wait_idle_and_set(17'd0);
		push_item(CMD_LOAD, 16'd0, 8'h00);
		rx_byte(C_NAK);
		rx_byte(C_ACK);

		wait_idle_and_set(17'h1FFFF);
		push_item(CMD_LOAD, 16'd0, 8'hFF);
		rx_byte(C_NAK);
		rx_byte(C_ACK);
		rx_byte(C_CAN);
		rx_byte(C_NAK);

		wait_idle_and_set(17'h10000);
		push_item(CMD_LOAD, 16'd0, 8'hA5);
		rx_byte(C_CRC);
		rx_byte(C_ACK);
		rx_byte(C_CAN);

		for (int p = 0; p < 6; p++) begin
			case (p % 6)
				0: sz = 17'd1;
				1: sz = 17'd127;
				2: sz = 17'd128;
				3: sz = 17'd129;
				4: sz = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(65536, 131071))
					: 17'($urandom_range(0, FILE_SPAN));
				default: sz = 17'($urandom_range(0, FILE_SPAN));
			endcase
			wait_idle_and_set(sz);
			no_idle = (p % 4 == 3);
			random_session(sz);
		end

		wait (pending_items.size() == 0 && !s_axis_tvalid && expected_beats.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
